// ----- rtl/core/bb3_pkg.sv -----
// Package: shared types and constants of the 3x3 box blur.
`default_nettype none
package bb3_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int REG_W = 11;
    localparam int PIX_W = 24;
    localparam logic [REG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [REG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Classified job handed from front to back.
    typedef struct packed {
        logic [PIX_W-1:0] px;      // pixel (zero on drain)
        logic             edge_emit; // emit right-edge result before shift
        logic             mid_emit;  // emit after shift
        logic             left;      // mid result is on left column
        logic             top;       // result row is row 0
        logic             bot;       // result row is last row
        logic             last_a;    // edge result is frame last
        logic             last_b;    // mid result is frame last
        logic [REG_W:0]   col;       // line store column
    } job_t;
endpackage
`default_nettype wire

// ----- rtl/core/bb3_front.sv -----
// Front: accepts items, tracks frame position, classifies each beat into a job.
`default_nettype none
module bb3_front #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic restart,
    input  wire logic [bb3_pkg::REG_W-1:0] w_reg,
    input  wire logic [bb3_pkg::REG_W-1:0] h_reg,
    input  wire logic take,
    input  wire logic mode,
    input  wire logic [bb3_pkg::PIX_W-1:0] in_pixel,
    output bb3_pkg::job_t job,
    output logic job_valid
);
    localparam int CW = $clog2(MAX_WIDTH + 1) + 1;
    localparam int RW = $clog2(MAX_HEIGHT + 3) + 1;
    logic [CW-1:0] w, in_col_reg, in_col_next, c, oc_reg, oc_next, c1;
    logic [RW-1:0] h, in_row_reg, in_row_next, or_reg, or_next, r1, r_orow;
    logic drain_phase, e_a, e_b, ok;

    always_comb
    begin
        w = CW'(w_reg);
        if (w < CW'(2)) w = CW'(2);
        if (w > CW'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
        h = RW'(h_reg);
        if (h < RW'(2)) h = RW'(2);
        if (h > RW'(MAX_HEIGHT)) h = RW'(MAX_HEIGHT);
        drain_phase = in_row_reg >= h;
        c = (in_col_reg >= w) ? w - CW'(1) : in_col_reg;
        ok = take && (mode == drain_phase);
        e_a = (c == '0) && (in_row_reg >= RW'(2));
        e_b = (c != '0) && (in_row_reg >= RW'(1));
        // out position after an edge emit
        oc_next = oc_reg;
        or_next = or_reg;
        job.last_a = (or_reg == h - RW'(1)) && (oc_reg == w - CW'(1));
        if (e_a)
        begin
            oc_next = oc_reg + CW'(1);
            if (oc_next >= w)
            begin
                oc_next = '0;
                or_next = or_reg + RW'(1);
            end
        end
        job.top = (or_reg == '0);
        job.bot = !(or_reg + RW'(1) < h);
        r_orow = or_next;
        job.left = (oc_next == '0);
        job.last_b = (r_orow == h - RW'(1)) && (oc_next == w - CW'(1));
        if (!e_a)
        begin
            job.top = (r_orow == '0);
            job.bot = !(r_orow + RW'(1) < h);
        end
        if (e_b)
        begin
            oc_next = oc_next + CW'(1);
            if (oc_next >= w)
            begin
                oc_next = '0;
                or_next = or_next + RW'(1);
            end
        end
        c1 = c + CW'(1);
        r1 = in_row_reg;
        if (c1 >= w)
        begin
            c1 = '0;
            r1 = r1 + RW'(1);
        end
        in_col_next = c1;
        in_row_next = r1;
        if (r1 > h + RW'(1) || (r1 == h + RW'(1) && c1 != '0))
        begin
            in_col_next = '0;
            in_row_next = '0;
            or_next = '0;
            oc_next = '0;
        end
        job.px = mode ? '0 : in_pixel;
        job.edge_emit = e_a;
        job.mid_emit = e_b;
        job.col = (bb3_pkg::REG_W+1)'(c);
    end

    assign job_valid = ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            oc_reg <= '0;
            or_reg <= '0;
        end
        else if (restart)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            oc_reg <= '0;
            or_reg <= '0;
        end
        else if (ok)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            oc_reg <= oc_next;
            or_reg <= or_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/bb3_back.sv -----
// Back: line stores, 3x3 window, averaging and result queue.
`default_nettype none
module bb3_back #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic restart,
    input  wire logic job_valid,
    input  bb3_pkg::job_t job,
    output logic busy_full,
    output logic res_valid,
    output logic [bb3_pkg::PIX_W-1:0] res_pixel,
    output logic res_last,
    input  wire logic res_pop
);
    localparam int AW = $clog2(MAX_WIDTH);
    logic [bb3_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [AW-1:0] addr;
    logic [bb3_pkg::PIX_W-1:0] a_rd, b_rd;

    // stage 1: memory read, job registered
    logic s1_valid_reg;
    bb3_pkg::job_t s1_reg;
    // window: col 0 oldest
    logic [bb3_pkg::PIX_W-1:0] win_reg [9];
    // stage 2: sums
    logic s2_valid_reg, s2_last_reg;
    logic [3:0] s2_n_reg;
    logic [11:0] s2_sum_reg [3];
    // result queue, 4 deep
    logic [bb3_pkg::PIX_W:0] q_mem [4];
    logic [1:0] q_wr_reg, q_rd_reg;
    logic [2:0] q_cnt_reg;
    logic stall;

    assign addr = job.col[AW-1:0];
    // two in flight + queue occupancy keep room
    assign busy_full = (q_cnt_reg >= 3'd2);
    assign stall = 1'b0;

    always_ff @(posedge clk)
    begin
        if (job_valid)
        begin
            upper_mem[addr] <= middle_mem[addr];
            middle_mem[addr] <= job.px;
            a_rd <= upper_mem[addr];
            b_rd <= middle_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= job_valid && !restart;
    end
    always_ff @(posedge clk)
    begin
        if (job_valid)
            s1_reg <= job;
    end

    // sum over window columns lo..2 and rows per top/bot
    function automatic logic [11:0] csum(input logic [bb3_pkg::PIX_W-1:0] wv [9],
                                          input int sh, input logic lcol,
                                          input logic top, input logic bot);
        logic [11:0] s;
        s = '0;
        for (int cc = 0; cc < 3; cc++)
            for (int rr = 0; rr < 3; rr++)
                if (!(cc == 0 && lcol) && !(rr == 0 && top) && !(rr == 2 && bot))
                    s = s + 12'(wv[cc*3+rr][sh +: 8]);
        return s;
    endfunction

    logic [bb3_pkg::PIX_W-1:0] new_win [9];
    logic do_emit, em_left, em_last;
    logic [bb3_pkg::PIX_W-1:0] em_win [9];
    always_comb
    begin
        for (int k = 0; k < 6; k++)
            new_win[k] = win_reg[k+3];
        new_win[6] = a_rd;
        new_win[7] = b_rd;
        new_win[8] = s1_reg.px;
        do_emit = s1_valid_reg && (s1_reg.edge_emit || s1_reg.mid_emit);
        if (s1_reg.edge_emit)
        begin
            // edge emit uses columns 1..2 of the old window
            em_win = win_reg;
            em_left = 1'b1;
            em_last = s1_reg.last_a;
        end
        else
        begin
            em_win = new_win;
            em_left = s1_reg.left;
            em_last = s1_reg.last_b;
        end
    end

    // left-style mask drops column 0 of the chosen window
    logic [11:0] sums [3];
    logic [3:0] ncount;
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            sums[ch] = csum(em_win, ch*8, em_left, s1_reg.top, s1_reg.bot);
        ncount = 4'(((em_left ? 2 : 3)) * (3 - (s1_reg.top ? 1 : 0) - (s1_reg.bot ? 1 : 0)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
            s2_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg)
                win_reg <= new_win;
            s2_valid_reg <= do_emit;
        end
    end
    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            s2_sum_reg <= sums;
            s2_n_reg <= ncount;
            s2_last_reg <= em_last;
        end
    end

    // divide by 4 via shift, by 6 or 9 via reciprocal and correction
    function automatic logic [7:0] divn(input logic [11:0] s, input logic [3:0] n);
        logic [23:0] p;
        logic [11:0] q;
        logic [15:0] r;
        case (n)
            4'd4: q = s >> 2;
            4'd6:
            begin
                p = 24'(s) * 24'd2731;
                q = 12'(p[23:14]);
                r = 16'(s) - 16'(q) * 16'd6;
                if (r >= 16'd6) q = q + 12'd1;
            end
            default:
            begin
                p = 24'(s) * 24'd1821;
                q = 12'(p[23:14]);
                r = 16'(s) - 16'(q) * 16'd9;
                if (r >= 16'd9) q = q + 12'd1;
            end
        endcase
        return q[7:0];
    endfunction

    logic [bb3_pkg::PIX_W-1:0] avg;
    assign avg = {divn(s2_sum_reg[2], s2_n_reg), divn(s2_sum_reg[1], s2_n_reg),
                  divn(s2_sum_reg[0], s2_n_reg)};

    logic q_push, q_pop;
    assign q_push = s2_valid_reg;
    assign q_pop = res_pop && (q_cnt_reg != '0);
    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_wr_reg] <= {s2_last_reg, avg};
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg <= '0;
            q_rd_reg <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (q_push) q_wr_reg <= q_wr_reg + 2'd1;
            if (q_pop) q_rd_reg <= q_rd_reg + 2'd1;
            q_cnt_reg <= q_cnt_reg + 3'(q_push) - 3'(q_pop);
        end
    end
    assign res_valid = (q_cnt_reg != '0) && !stall;
    assign res_pixel = q_mem[q_rd_reg][bb3_pkg::PIX_W-1:0];
    assign res_last = q_mem[q_rd_reg][bb3_pkg::PIX_W];
endmodule
`default_nettype wire

// ----- rtl/core/box_blur_3x3_edge_clipped.sv -----
// Top level: 3x3 edge-clipped box blur of an RGB raster stream.
// Path: each result is read from the line stores, summed over its window, then divided into the result queue.
// Throughput: one beat per cycle while full is low; full rises while two or more
// results wait in the 4-deep result queue, so a stalled consumer backs up the input.
// Results trail pixels by one row plus one pixel; width+1 drain beats flush a frame.
// Reset (async, rst_n low): counters, window and queue clear; size regs go to 640x480.
`default_nettype none
module box_blur_3x3_edge_clipped #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic full,
    input  wire logic mode,
    input  wire logic [bb3_pkg::PIX_W-1:0] in_pixel,
    output logic empty,
    input  wire logic pop,
    output logic [bb3_pkg::PIX_W-1:0] out_pixel,
    output logic last_of_frame,
    input  wire logic cfg_we,
    input  wire logic cfg_index,
    input  wire logic [bb3_pkg::REG_W-1:0] cfg_data
);
    logic [bb3_pkg::REG_W-1:0] w_reg, h_reg;
    logic restart, job_valid, res_valid, busy;
    bb3_pkg::job_t job;

    // any register write restarts the frame
    assign restart = cfg_we;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= bb3_pkg::WIDTH_RESET;
            h_reg <= bb3_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bb3_pkg::REG_FRAME_WIDTH) w_reg <= cfg_data;
            if (cfg_index == bb3_pkg::REG_FRAME_HEIGHT) h_reg <= cfg_data;
        end
    end

    assign full = busy;

    bb3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk, .rst_n, .restart, .w_reg, .h_reg,
        .take(push && !full), .mode, .in_pixel, .job, .job_valid
    );

    bb3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk, .rst_n, .restart, .job_valid, .job, .busy_full(busy),
        .res_valid, .res_pixel(out_pixel), .res_last(last_of_frame), .res_pop(pop)
    );

    assign empty = !res_valid;

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full with empty result queue");
    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_pixel) && $stable(last_of_frame)))
        else $error("waiting result beat changed");
    a_cfg_reset: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !u_back.s1_valid_reg)
        else $error("stage valid after restart");
endmodule
`default_nettype wire
